// File: rtl/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg: shared types, constants and microprogram
// Control word layout, sequencer status, and the read-only program that
// drives the modular exponentiation datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int MOD_BITS_DEF = 16;
  localparam int FIELD_W      = 16;
  localparam int CFG_W        = 16;
  localparam int REG_IDX_W    = 1;
  localparam int PC_W         = 3;

  localparam logic [REG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_EXPONENT = 1'b1;

  localparam logic [CFG_W-1:0] MODULUS_RST  = 16'd2;
  localparam logic [CFG_W-1:0] EXPONENT_RST = 16'd1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MM_STEP,
    OP_RED_DONE,
    OP_BIT_START,
    OP_BIT_DONE,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  typedef enum logic [1:0] {
    LOOP_NONE,
    LOOP_CNT,
    LOOP_BITS,
    LOOP_ALWAYS
  } loop_t;

  typedef struct packed {
    op_t             op;
    hold_t           hold;
    loop_t           loop_sel;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    op_t  op;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic bits_last;
  } dp_stat_t;

  typedef struct packed {
    logic     in_valid;
    logic     out_busy;
    dp_stat_t dp;
  } seq_stat_t;

  localparam logic [PC_W-1:0] ST_ACCEPT    = 3'd0;
  localparam logic [PC_W-1:0] ST_RED_STEP  = 3'd1;
  localparam logic [PC_W-1:0] ST_RED_DONE  = 3'd2;
  localparam logic [PC_W-1:0] ST_BIT_START = 3'd3;
  localparam logic [PC_W-1:0] ST_BIT_STEP  = 3'd4;
  localparam logic [PC_W-1:0] ST_BIT_DONE  = 3'd5;
  localparam logic [PC_W-1:0] ST_EMIT      = 3'd6;

  function automatic ctl_word_t prog_word(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    unique case (pc)
      ST_ACCEPT:    w = '{OP_ACCEPT,    HOLD_IN,   LOOP_NONE,   ST_ACCEPT};
      ST_RED_STEP:  w = '{OP_MM_STEP,   HOLD_NONE, LOOP_CNT,    ST_RED_STEP};
      ST_RED_DONE:  w = '{OP_RED_DONE,  HOLD_NONE, LOOP_NONE,   ST_ACCEPT};
      ST_BIT_START: w = '{OP_BIT_START, HOLD_NONE, LOOP_NONE,   ST_ACCEPT};
      ST_BIT_STEP:  w = '{OP_MM_STEP,   HOLD_NONE, LOOP_CNT,    ST_BIT_STEP};
      ST_BIT_DONE:  w = '{OP_BIT_DONE,  HOLD_NONE, LOOP_BITS,   ST_BIT_START};
      ST_EMIT:      w = '{OP_EMIT,      HOLD_OUT,  LOOP_ALWAYS, ST_ACCEPT};
      default:      w = '{OP_NOP,       HOLD_NONE, LOOP_ALWAYS, ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mexp_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_modmul: bit-serial modular multiplier lane
// Interleaved a*b mod m, one bit of b per cycle while step is high, MSB first. Requires a < m.
// ----------------------------------------------------------------------------
module mexp_modmul
  import mexp_pkg::*;
#(
  parameter int W = MOD_BITS_DEF
) (
  input  logic         clk,
  input  logic         start,
  input  logic         step,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic [W-1:0] r
);

  logic [W-1:0] a_q;
  logic [W-1:0] b_q;
  logic [W:0]   dbl;
  logic [W:0]   sum;
  logic [W-1:0] dbl_red;
  logic [W-1:0] r_next;

  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : W'(dbl);
    sum     = {1'b0, dbl_red} + (b_q[W-1] ? {1'b0, a_q} : '0);
    r_next  = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : W'(sum);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      r   <= '0;
    end else if (step) begin
      b_q <= {b_q[W-2:0], 1'b0};
      r   <= r_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mexp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_dp: exponentiation datapath
// Base power, accumulator, exponent shifter, step counters and two
// modular multiplier lanes (acc*base and base*base).
// ----------------------------------------------------------------------------
module mexp_dp
  import mexp_pkg::*;
#(
  parameter int W = MOD_BITS_DEF
) (
  input  logic         clk,
  input  cmd_t         cmd,
  input  logic [W-1:0] m_w,
  input  logic [W-1:0] e_w,
  input  logic [W-1:0] base_w,
  output logic [W-1:0] acc,
  output dp_stat_t     stat
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     base_r;
  logic [W-1:0]     ebits;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] bitcnt;
  logic             do_accept;
  logic             do_step;
  logic             do_red_done;
  logic             do_bit_start;
  logic             do_bit_done;
  logic [W-1:0]     a_lane_a;
  logic [W-1:0]     a_lane_b;
  logic [W-1:0]     r_lane_a;
  logic [W-1:0]     r_lane_b;

  assign do_accept    = cmd.exec && (cmd.op == OP_ACCEPT);
  assign do_step      = cmd.exec && (cmd.op == OP_MM_STEP);
  assign do_red_done  = cmd.exec && (cmd.op == OP_RED_DONE);
  assign do_bit_start = cmd.exec && (cmd.op == OP_BIT_START);
  assign do_bit_done  = cmd.exec && (cmd.op == OP_BIT_DONE);

  // base reduction runs as 1 * base mod m
  assign a_lane_a = do_accept ? W'(1) : base_r;
  assign a_lane_b = do_accept ? base_w : acc;

  mexp_modmul #(.W(W)) u_lane_mul (
    .clk   (clk),
    .start (do_accept || do_bit_start),
    .step  (do_step),
    .a     (a_lane_a),
    .b     (a_lane_b),
    .m     (m_w),
    .r     (r_lane_a)
  );

  mexp_modmul #(.W(W)) u_lane_sqr (
    .clk   (clk),
    .start (do_bit_start),
    .step  (do_step),
    .a     (base_r),
    .b     (base_r),
    .m     (m_w),
    .r     (r_lane_b)
  );

  always_ff @(posedge clk) begin
    if (do_accept) begin
      acc    <= W'(1);
      ebits  <= e_w;
      bitcnt <= CNT_W'(W);
      cnt    <= CNT_W'(W);
    end else if (do_bit_start) begin
      cnt <= CNT_W'(W);
    end else if (do_step) begin
      cnt <= cnt - CNT_W'(1);
    end else if (do_red_done) begin
      base_r <= r_lane_a;
    end else if (do_bit_done) begin
      if (ebits[0]) begin
        acc <= r_lane_a;
      end
      base_r <= r_lane_b;
      ebits  <= ebits >> 1;
      bitcnt <= bitcnt - CNT_W'(1);
    end
  end

  assign stat.cnt_last  = (cnt == CNT_W'(1));
  assign stat.bits_last = (bitcnt == CNT_W'(1));

endmodule
`default_nettype wire

// File: rtl/mexp_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_seq: microprogram sequencer
// Step counter over the program table with hold and conditional jumps.
// ----------------------------------------------------------------------------
module mexp_seq
  import mexp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  seq_stat_t stat,
  output cmd_t      cmd
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctl_word_t       word;
  logic            held;
  logic            take;

  assign word = prog_word(pc);

  always_comb begin
    unique case (word.hold)
      HOLD_IN:  held = !stat.in_valid;
      HOLD_OUT: held = stat.out_busy;
      default:  held = 1'b0;
    endcase
  end

  always_comb begin
    unique case (word.loop_sel)
      LOOP_CNT:    take = !stat.dp.cnt_last;
      LOOP_BITS:   take = !stat.dp.bits_last;
      LOOP_ALWAYS: take = 1'b1;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    if (held) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = word.target;
    end else begin
      pc_next = PC_W'(pc + PC_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

  assign cmd.op   = word.op;
  assign cmd.exec = !held;

endmodule
`default_nettype wire

// File: rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus
// Right-to-left square-and-multiply under a microcoded sequencer.
// ----------------------------------------------------------------------------
// One item is in work at a time. The base is first reduced, then each of
// the MOD_BITS exponent bits runs a multiply and a square side by side in
// the bit-serial modular multipliers, which retire one multiplier bit per
// cycle. The next item is accepted in the cycle after the result enters
// the output register, which holds it until taken. A modulus below two
// gives 0. The user must write configuration only while no item is in
// work; the block itself does not enforce this.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_enable,
  input  logic [REG_IDX_W-1:0] reg_index,
  input  logic [CFG_W-1:0]     write_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FIELD_W-1:0]   base_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FIELD_W-1:0]   power_result
);

  logic [CFG_W-1:0]    modulus;
  logic [CFG_W-1:0]    exponent;
  logic [MOD_BITS-1:0] m_w;
  logic [MOD_BITS-1:0] e_w;
  logic [MOD_BITS-1:0] base_w;
  logic [MOD_BITS-1:0] acc;
  cmd_t                cmd;
  dp_stat_t            dp_stat;
  seq_stat_t           seq_stat;
  logic                emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RST;
      exponent <= EXPONENT_RST;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_MODULUS:  modulus  <= write_data;
        REG_EXPONENT: exponent <= write_data;
      endcase
    end
  end

  assign m_w    = MOD_BITS'(modulus);
  assign e_w    = MOD_BITS'(exponent);
  assign base_w = MOD_BITS'(base_value);

  assign seq_stat.in_valid = in_valid;
  assign seq_stat.out_busy = out_valid && out_stall;
  assign seq_stat.dp       = dp_stat;

  mexp_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (seq_stat),
    .cmd  (cmd)
  );

  mexp_dp #(.W(MOD_BITS)) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .m_w    (m_w),
    .e_w    (e_w),
    .base_w (base_w),
    .acc    (acc),
    .stat   (dp_stat)
  );

  assign in_stall = (cmd.op != OP_ACCEPT);
  assign emit     = cmd.exec && (cmd.op == OP_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      power_result <= (m_w < MOD_BITS'(2)) ? '0 : FIELD_W'(acc);
    end
  end

endmodule
`default_nettype wire

// File: rtl/mexp_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_check: port-level checks for modular_exponentiation
// Output handshake rules and item sequencing seen at the ports.
// ----------------------------------------------------------------------------
module mexp_check
  import mexp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FIELD_W-1:0] power_result
);

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_out_stable : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(power_result))
    else $error("stalled result changed");

  a_busy_after_in : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted right after the first");

  a_result_from_work : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

endmodule

bind modular_exponentiation mexp_check u_mexp_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .power_result (power_result)
);
`default_nettype wire
